// ----- rtl/fpsa_pkg.sv -----
package fpsa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 52;

  localparam int FRAME_W = ADDR_BITS - PAGE_SHIFT;
  localparam int PTR_W   = $clog2(MAX_PAGES);
  localparam int DEPTH_W = $clog2(MAX_PAGES + 1);
  localparam int COUNT_W = 13;
  localparam int CMP_W   = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;
  localparam logic [COUNT_W-1:0] TOTAL_LIMIT = '1;

  // slave side: tdata = region_base, region_length, release_address; tuser = opcode, usable
  localparam int S_BASE_LSB  = 0;
  localparam int S_LEN_LSB   = ADDR_BITS;
  localparam int S_REL_LSB   = 2 * ADDR_BITS;
  localparam int S_TDATA_W   = ((3 * ADDR_BITS + 7) / 8) * 8;
  localparam int S_TUSER_W   = 3;

  // master side: tdata = page_address, total, free, used; tuser = status
  localparam int M_ADDR_LSB  = 0;
  localparam int M_TOTAL_LSB = ADDR_BITS;
  localparam int M_FREE_LSB  = ADDR_BITS + COUNT_W;
  localparam int M_USED_LSB  = ADDR_BITS + 2 * COUNT_W;
  localparam int M_TDATA_W   = ((ADDR_BITS + 3 * COUNT_W + 7) / 8) * 8;
  localparam int M_TUSER_W   = 2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } fpsa_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } fpsa_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REGION,
    S_POP,
    S_FINISH
  } fpsa_state_t;

  typedef struct packed {
    logic take;
    logic push_free;
    logic pop;
    logic set_empty;
    logic set_full;
    logic push_region;
    logic capture_pop;
    logic emit;
  } fpsa_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       usable;
    logic       empty;
    logic       full;
    logic       region_done;
    logic       out_free;
  } fpsa_stat_t;

endpackage

// ----- rtl/fpsa_ram.sv -----
module fpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fpsa_ctrl.sv -----
module fpsa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  fpsa_pkg::fpsa_stat_t   stat,
  input  logic                   in_valid,
  output logic                   in_ready,
  output fpsa_pkg::fpsa_cmd_t    cmd
);

  fpsa_pkg::fpsa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      fpsa_pkg::S_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.take   = 1'b1;
          state_next = fpsa_pkg::S_FINISH;
          if (stat.opcode == fpsa_pkg::OP_ADD) begin
            if (stat.usable) begin
              state_next = fpsa_pkg::S_REGION;
            end
          end else if (stat.opcode == fpsa_pkg::OP_ALLOC) begin
            if (stat.empty) begin
              cmd.set_empty = 1'b1;
            end else begin
              cmd.pop    = 1'b1;
              state_next = fpsa_pkg::S_POP;
            end
          end else if (stat.opcode == fpsa_pkg::OP_FREE) begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.push_free = 1'b1;
            end
          end
        end
      end
      fpsa_pkg::S_REGION: begin
        // one page pushed per cycle until the region runs out or the stack fills
        if (stat.region_done) begin
          state_next = fpsa_pkg::S_FINISH;
        end else if (stat.full) begin
          cmd.set_full = 1'b1;
          state_next   = fpsa_pkg::S_FINISH;
        end else begin
          cmd.push_region = 1'b1;
        end
      end
      fpsa_pkg::S_POP: begin
        cmd.capture_pop = 1'b1;
        state_next      = fpsa_pkg::S_FINISH;
      end
      fpsa_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fpsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fpsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fpsa_datapath.sv -----
module fpsa_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fpsa_pkg::fpsa_cmd_t              cmd,
  output fpsa_pkg::fpsa_stat_t             stat,
  input  logic [fpsa_pkg::S_TDATA_W-1:0]   in_data,
  input  logic [fpsa_pkg::S_TUSER_W-1:0]   in_user,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fpsa_pkg::M_TDATA_W-1:0]   out_data,
  output logic [fpsa_pkg::M_TUSER_W-1:0]   out_user
);

  localparam int AW = fpsa_pkg::ADDR_BITS;
  localparam int PS = fpsa_pkg::PAGE_SHIFT;
  localparam int FW = fpsa_pkg::FRAME_W;
  localparam int CW = fpsa_pkg::COUNT_W;

  logic [fpsa_pkg::DEPTH_W-1:0] depth;
  logic [CW-1:0]                total;
  logic [FW:0]                  frame_cur;
  logic [FW:0]                  frame_end;
  logic [AW-1:0]                res_addr;
  fpsa_pkg::fpsa_status_t       res_status;

  logic [AW-1:0]   base;
  logic [AW-1:0]   len;
  logic [AW-1:0]   rel;
  logic [AW:0]     sum;
  logic [FW:0]     first;
  logic [FW:0]     endp;
  logic [CW-1:0]   depth_cnt;
  logic [fpsa_pkg::CMP_W-1:0] total_w;
  logic [fpsa_pkg::CMP_W-1:0] depth_w;
  logic [CW-1:0]   used;

  logic                         ram_we;
  logic [fpsa_pkg::PTR_W-1:0]   ram_waddr;
  logic [FW-1:0]                ram_wdata;
  logic [fpsa_pkg::PTR_W-1:0]   ram_raddr;
  logic [FW-1:0]                ram_rdata;
  logic [fpsa_pkg::DEPTH_W-1:0] depth_dec;

  assign base = in_data[fpsa_pkg::S_BASE_LSB +: AW];
  assign len  = in_data[fpsa_pkg::S_LEN_LSB +: AW];
  assign rel  = in_data[fpsa_pkg::S_REL_LSB +: AW];

  // base aligned up, end aligned down; end clamps to the top of the address space
  assign sum   = {1'b0, base} + {1'b0, len};
  assign first = {1'b0, base[AW-1:PS]} + (FW+1)'(|base[PS-1:0]);
  assign endp  = sum[AW] ? {1'b1, {FW{1'b0}}} : {1'b0, sum[AW-1:PS]};

  assign stat.opcode      = in_user[1:0];
  assign stat.usable      = in_user[2];
  assign stat.empty       = (depth == '0);
  assign stat.full        = (depth == fpsa_pkg::DEPTH_W'(fpsa_pkg::MAX_PAGES));
  assign stat.region_done = (frame_cur >= frame_end);
  assign stat.out_free    = !out_valid || out_ready;

  assign depth_dec = depth - 1'b1;
  assign ram_we    = cmd.push_free || cmd.push_region;
  assign ram_waddr = depth[fpsa_pkg::PTR_W-1:0];
  assign ram_wdata = cmd.push_free ? rel[AW-1:PS] : frame_cur[FW-1:0];
  assign ram_raddr = depth_dec[fpsa_pkg::PTR_W-1:0];

  fpsa_ram #(
    .WIDTH(FW),
    .DEPTH(fpsa_pkg::MAX_PAGES)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.pop),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign total_w   = fpsa_pkg::CMP_W'(total);
  assign depth_w   = fpsa_pkg::CMP_W'(depth);
  assign depth_cnt = CW'(depth);
  assign used      = (total_w > depth_w) ? CW'(total_w - depth_w) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      total <= '0;
    end else begin
      if (cmd.push_free || cmd.push_region) begin
        depth <= depth + 1'b1;
      end else if (cmd.pop) begin
        depth <= depth_dec;
      end
      if (cmd.push_region && total != fpsa_pkg::TOTAL_LIMIT) begin
        total <= total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_addr   <= '0;
      res_status <= fpsa_pkg::STAT_OK;
      frame_cur  <= first;
      frame_end  <= endp;
    end
    if (cmd.push_region) begin
      frame_cur <= frame_cur + 1'b1;
    end
    if (cmd.set_empty) begin
      res_status <= fpsa_pkg::STAT_EMPTY;
    end
    if (cmd.set_full) begin
      res_status <= fpsa_pkg::STAT_FULL;
    end
    if (cmd.capture_pop) begin
      res_addr <= {ram_rdata, {PS{1'b0}}};
    end
  end

  // output register, parts the result from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= fpsa_pkg::M_TDATA_W'({used, depth_cnt, total, res_addr});
      out_user <= res_status;
    end
  end

endmodule

// ----- rtl/free_page_stack_allocator.sv -----
// free page stack allocator
// slave channel (s_*) takes one request item; tuser carries the opcode (add region,
// alloc, free) and the usable flag, tdata the region base, region length and the
// address handed back on free
// master channel (m_*) returns exactly one result item per request: page address,
// status in tuser, and the total, free and used page counts after the request
// from accept to result valid: free, unknown opcode, empty alloc and unusable regions
// go straight to the result; alloc first does the registered stack read; add region
// first pushes N pages, one page per cycle through the stack memory's single write port
// one request is in flight at a time; s_tready is high only while the block is idle,
// so the next item is taken in the cycle after the previous result is loaded
// the result sits in an output register; a new item is accepted while it waits, and
// the next result is held back until m_tready frees that register
// reset (rst, synchronous) empties the stack and clears the page counts; the stack
// memory itself is not cleared, entries are only read after being pushed
module free_page_stack_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // region_base, region_length, release_address
  input  logic [fpsa_pkg::S_TDATA_W-1:0]   s_tdata,
  // opcode, region_usable
  input  logic [fpsa_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // page_address, total_count, free_count, used_count
  output logic [fpsa_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic [fpsa_pkg::M_TUSER_W-1:0]   m_tuser
);

  fpsa_pkg::fpsa_cmd_t  cmd;
  fpsa_pkg::fpsa_stat_t stat;

  fpsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .cmd     (cmd)
  );

  fpsa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata),
    .out_user (m_tuser)
  );

endmodule

// ----- rtl/fpsa_checker.sv -----
module fpsa_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [fpsa_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic [fpsa_pkg::M_TUSER_W-1:0]   m_tuser
);

  logic [fpsa_pkg::ADDR_BITS-1:0] r_addr;
  logic [fpsa_pkg::COUNT_W-1:0]   r_total;
  logic [fpsa_pkg::COUNT_W-1:0]   r_free;
  logic [fpsa_pkg::COUNT_W-1:0]   r_used;

  assign r_addr  = m_tdata[fpsa_pkg::M_ADDR_LSB +: fpsa_pkg::ADDR_BITS];
  assign r_total = m_tdata[fpsa_pkg::M_TOTAL_LSB +: fpsa_pkg::COUNT_W];
  assign r_free  = m_tdata[fpsa_pkg::M_FREE_LSB +: fpsa_pkg::COUNT_W];
  assign r_used  = m_tdata[fpsa_pkg::M_USED_LSB +: fpsa_pkg::COUNT_W];

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((r_total > r_free) ? (r_used == r_total - r_free) : (r_used == '0)))
    else $error("used count disagrees with total and free");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fpsa_pkg::STAT_EMPTY |-> r_addr == '0 && r_free == '0)
    else $error("empty status with pages on the stack");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r_free <= fpsa_pkg::COUNT_W'(fpsa_pkg::MAX_PAGES))
    else $error("free count beyond stack size");

endmodule

bind free_page_stack_allocator fpsa_checker u_fpsa_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
